@@ design/tdrs_pkg.sv @@
`timescale 1ns / 1ps

package tdrs_pkg;

  localparam int SAMPLE_BITS_DEF      = 10;
  localparam int TICK_BITS_DEF        = 16;
  localparam int CHANGE_DEAD_BAND_DEF = 4;
  localparam int RANGE_DIVIDER_DEF    = 20;

  localparam int CFG_BITS       = 15;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CMD_BITS       = 3;
  localparam int PERCENT_BITS   = 7;
  localparam int PERCENT_FULL   = 100;
  localparam int PHASE_BITS     = 5;
  localparam int EVENT_BITS     = 4;
  localparam int WORD_BITS      = 32;

  // relay, idle and lit flags, phase and event ahead of the two levels
  localparam int RES_FIXED_BITS = 3 + PHASE_BITS + EVENT_BITS;

  typedef logic [CFG_BITS-1:0] cfg_word_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK      = 3'd0,
    CMD_TOGGLE    = 3'd1,
    CMD_POWER_ON  = 3'd2,
    CMD_POWER_OFF = 3'd3,
    CMD_CALIBRATE = 3'd4,
    CMD_SET_LEVEL = 3'd5,
    CMD_QUIT      = 3'd6
  } cmd_t;

  typedef enum logic [PHASE_BITS-1:0] {
    PH_IDLE, PH_TOG, PH_TOG_FIN,
    PH_ON, PH_ON_PRESS, PH_ON_CHECK,
    PH_OFF, PH_OFF_PRESS, PH_OFF_CHECK,
    PH_CAL, PH_CAL_ACC, PH_CAL_LIM, PH_CAL_REL, PH_CAL_ACC2, PH_CAL_LIM2,
    PH_SET, PH_SET_GETON, PH_SET_ACC, PH_SET_REL, PH_SET_ACC2, PH_SET_SEEK,
    PH_SET_FIN
  } phase_t;

  typedef enum logic [EVENT_BITS-1:0] {
    EV_NONE, EV_TIMEOUT, EV_ALREADY_ON, EV_ALREADY_OFF, EV_NOT_ON, EV_NOT_OFF,
    EV_ON_TARGET, EV_CALIBRATED, EV_FINALIZED, EV_QUIT
  } event_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_TOGGLE_PRESS   = 3'd0,
    CFG_TOGGLE_GAP     = 3'd1,
    CFG_POWER_ON_WAIT  = 3'd2,
    CFG_POWER_OFF_WAIT = 3'd3,
    CFG_RAMP_START     = 3'd4,
    CFG_TRAVEL_LIMIT   = 3'd5,
    CFG_SEQ_TIMEOUT    = 3'd6,
    CFG_SENSE_INTERVAL = 3'd7
  } cfg_sel_t;

  typedef struct packed {
    cfg_word_t press_ticks;
    cfg_word_t gap_ticks;
    cfg_word_t on_wait_ticks;
    cfg_word_t off_wait_ticks;
    cfg_word_t ramp_start_ticks;
    cfg_word_t travel_limit_ticks;
    cfg_word_t timeout_ticks;
    cfg_word_t sense_interval_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    press_ticks:          15'd2,
    gap_ticks:            15'd2,
    on_wait_ticks:        15'd10,
    off_wait_ticks:       15'd10,
    ramp_start_ticks:     15'd5,
    travel_limit_ticks:   15'd100,
    timeout_ticks:        15'd200,
    sense_interval_ticks: 15'd2
  };

endpackage

@@ design/tdrs_if.sv @@
`timescale 1ns / 1ps

interface tdrs_item_if #(
  parameter int SAMPLE_BITS = tdrs_pkg::SAMPLE_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [tdrs_pkg::CMD_BITS-1:0]     command;
  logic [SAMPLE_BITS-1:0]            light_sample;
  logic [tdrs_pkg::PERCENT_BITS-1:0] level_percent;

  modport source (output valid, command, light_sample, level_percent, input ready);
  modport sink (input valid, command, light_sample, level_percent, output ready);
endinterface

interface tdrs_res_if #(
  parameter int SAMPLE_BITS = tdrs_pkg::SAMPLE_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic                            relay_closed;
  logic                            is_idle;
  logic                            lamp_lit;
  logic [tdrs_pkg::PHASE_BITS-1:0] phase;
  logic [tdrs_pkg::EVENT_BITS-1:0] event_res;
  logic [SAMPLE_BITS-1:0]          low_level;
  logic [SAMPLE_BITS-1:0]          high_level;

  modport source (
    output valid, relay_closed, is_idle, lamp_lit, phase, event_res, low_level, high_level,
    input ready
  );
  modport sink (
    input valid, relay_closed, is_idle, lamp_lit, phase, event_res, low_level, high_level,
    output ready
  );
endinterface

@@ design/touch_dimmer_relay_sequencer_core.sv @@
`timescale 1ns / 1ps

// Relay sequencer for a touch dimmer lamp with light sensor feedback.
// item_in carries command items (toggle, power on, power off, calibrate,
// set level, quit) and tick items with one averaged light sample; every
// accepted item yields exactly one item on res_out with the relay drive,
// idle flag, lamp lit flag, phase, event code and the stored levels.
// Timing registers are written through cfg_we / cfg_index / cfg_data. The
// user must write them only while the block is idle; the block itself does
// not enforce this. Press, wait, timeout and sense intervals count ticks.
// Throughput: one item per cycle while the result queue has room; each
// item is a single state update, and the set-level target (percent table
// times range) and the dead band (range times divider reciprocal) each
// take one multiplier. A two-entry result queue sits on the output side:
// with res_out stalled, one more item is still taken, then item_in.ready
// drops until a result leaves. Nothing is lost or repeated under stalls.
// Reset (rst, synchronous): timing registers to their defaults, idle phase,
// relay open, tick counter zero, minimum level zero, maximum level full
// scale, dead band zero, result queue empty.
module touch_dimmer_relay_sequencer_core #(
  parameter int SAMPLE_BITS      = tdrs_pkg::SAMPLE_BITS_DEF,
  parameter int TICK_BITS        = tdrs_pkg::TICK_BITS_DEF,
  parameter int CHANGE_DEAD_BAND = tdrs_pkg::CHANGE_DEAD_BAND_DEF,
  parameter int RANGE_DIVIDER    = tdrs_pkg::RANGE_DIVIDER_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tdrs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  tdrs_pkg::cfg_word_t                 cfg_data,
  tdrs_item_if.sink                           item_in,
  tdrs_res_if.source                          res_out
);

  localparam int RES_BITS   = tdrs_pkg::RES_FIXED_BITS + 2 * SAMPLE_BITS;
  localparam int LOW_LSB    = SAMPLE_BITS;
  localparam int EV_LSB     = 2 * SAMPLE_BITS;
  localparam int PHASE_LSB  = EV_LSB + tdrs_pkg::EVENT_BITS;
  localparam int LIT_BIT    = PHASE_LSB + tdrs_pkg::PHASE_BITS;
  localparam int IDLE_BIT   = LIT_BIT + 1;
  localparam int RELAY_BIT  = IDLE_BIT + 1;

  tdrs_pkg::cfg_t         cfg;
  logic                   accept;
  logic                   can_push;
  logic [SAMPLE_BITS-1:0] target_calc;
  logic [SAMPLE_BITS-1:0] band_calc;
  logic [SAMPLE_BITS-1:0] min_level;
  logic [SAMPLE_BITS-1:0] max_level;
  logic [RES_BITS-1:0]    res_word;
  logic [RES_BITS-1:0]    out_word;

  assign item_in.ready = can_push;
  assign accept        = item_in.valid && can_push;

  tdrs_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  tdrs_scale #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .RANGE_DIVIDER (RANGE_DIVIDER)
  ) u_scale (
    .level_percent (item_in.level_percent),
    .min_level     (min_level),
    .max_level     (max_level),
    .target_level  (target_calc),
    .band          (band_calc)
  );

  tdrs_seq #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .TICK_BITS        (TICK_BITS),
    .CHANGE_DEAD_BAND (CHANGE_DEAD_BAND)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .command      (item_in.command),
    .light_sample (item_in.light_sample),
    .cfg          (cfg),
    .target_calc  (target_calc),
    .band_calc    (band_calc),
    .min_level    (min_level),
    .max_level    (max_level),
    .res_word     (res_word)
  );

  tdrs_res_queue #(
    .WIDTH (RES_BITS)
  ) u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res_word),
    .can_push  (can_push),
    .pop_valid (res_out.valid),
    .pop_ready (res_out.ready),
    .pop_data  (out_word)
  );

  assign res_out.relay_closed = out_word[RELAY_BIT];
  assign res_out.is_idle      = out_word[IDLE_BIT];
  assign res_out.lamp_lit     = out_word[LIT_BIT];
  assign res_out.phase        = out_word[PHASE_LSB +: tdrs_pkg::PHASE_BITS];
  assign res_out.event_res    = out_word[EV_LSB +: tdrs_pkg::EVENT_BITS];
  assign res_out.low_level    = out_word[LOW_LSB +: SAMPLE_BITS];
  assign res_out.high_level   = out_word[0 +: SAMPLE_BITS];

endmodule

@@ design/tdrs_cfg_regs.sv @@
`timescale 1ns / 1ps

module tdrs_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                we,
  input  logic [tdrs_pkg::CFG_INDEX_BITS-1:0] index,
  input  tdrs_pkg::cfg_word_t                 data,
  output tdrs_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= tdrs_pkg::CFG_RESET;
    end else if (we) begin
      case (tdrs_pkg::cfg_sel_t'(index))
        tdrs_pkg::CFG_TOGGLE_PRESS:   cfg.press_ticks          <= data;
        tdrs_pkg::CFG_TOGGLE_GAP:     cfg.gap_ticks            <= data;
        tdrs_pkg::CFG_POWER_ON_WAIT:  cfg.on_wait_ticks        <= data;
        tdrs_pkg::CFG_POWER_OFF_WAIT: cfg.off_wait_ticks       <= data;
        tdrs_pkg::CFG_RAMP_START:     cfg.ramp_start_ticks     <= data;
        tdrs_pkg::CFG_TRAVEL_LIMIT:   cfg.travel_limit_ticks   <= data;
        tdrs_pkg::CFG_SEQ_TIMEOUT:    cfg.timeout_ticks        <= data;
        tdrs_pkg::CFG_SENSE_INTERVAL: cfg.sense_interval_ticks <= data;
        default: ;
      endcase
    end
  end

endmodule

@@ design/tdrs_scale.sv @@
`timescale 1ns / 1ps

module tdrs_scale #(
  parameter int SAMPLE_BITS   = tdrs_pkg::SAMPLE_BITS_DEF,
  parameter int RANGE_DIVIDER = tdrs_pkg::RANGE_DIVIDER_DEF
) (
  input  logic [tdrs_pkg::PERCENT_BITS-1:0] level_percent,
  input  logic [SAMPLE_BITS-1:0]            min_level,
  input  logic [SAMPLE_BITS-1:0]            max_level,
  output logic [SAMPLE_BITS-1:0]            target_level,
  output logic [SAMPLE_BITS-1:0]            band
);

  // percent reciprocal: 2^RN > 100 * largest span keeps the truncated quotient exact
  localparam int RN           = SAMPLE_BITS + tdrs_pkg::PERCENT_BITS;
  localparam int RW           = RN + 1;
  localparam int RECIP_COUNT  = 2 ** tdrs_pkg::PERCENT_BITS;
  localparam int BN           = SAMPLE_BITS + 8;
  localparam int BW           = BN + 1;
  localparam longint BAND_RECIP_VAL = ((longint'(1) << BN) + RANGE_DIVIDER - 1) / RANGE_DIVIDER;
  localparam logic [BW-1:0] BAND_RECIP = BW'(BAND_RECIP_VAL);

  logic [RW-1:0]                 recip [RECIP_COUNT];
  logic signed [SAMPLE_BITS:0]   span;
  logic [SAMPLE_BITS:0]          span_mag;
  logic [SAMPLE_BITS-1:0]        span_abs;
  logic [SAMPLE_BITS+RW-1:0]     pct_prod;
  logic [SAMPLE_BITS:0]          step;
  logic signed [SAMPLE_BITS+1:0] step_signed;
  logic signed [SAMPLE_BITS+2:0] raw_target;
  logic [SAMPLE_BITS+BW-1:0]     band_prod;

  for (genvar g = 0; g < RECIP_COUNT; g++) begin : g_recip
    localparam logic [RW-1:0] R = RW'(((longint'(g) << RN) + tdrs_pkg::PERCENT_FULL - 1)
                                      / tdrs_pkg::PERCENT_FULL);
    assign recip[g] = R;
  end

  always_comb begin
    span        = $signed({1'b0, max_level}) - $signed({1'b0, min_level});
    span_mag    = span[SAMPLE_BITS] ? -span : span;
    span_abs    = span_mag[SAMPLE_BITS-1:0];
    pct_prod    = (SAMPLE_BITS+RW)'(span_abs) * (SAMPLE_BITS+RW)'(recip[level_percent]);
    step        = pct_prod[RN +: SAMPLE_BITS+1];
    // quotient truncates toward zero when the stored range is inverted
    step_signed = span[SAMPLE_BITS] ? -$signed({1'b0, step}) : $signed({1'b0, step});
    raw_target  = $signed({2'b00, min_level}) + (SAMPLE_BITS+3)'(step_signed);
    if (raw_target[SAMPLE_BITS+2]) begin
      target_level = '0;
    end else if (|raw_target[SAMPLE_BITS+1:SAMPLE_BITS]) begin
      target_level = '1;
    end else begin
      target_level = raw_target[SAMPLE_BITS-1:0];
    end
    // range is never inverted right after a full calibration
    band_prod = (SAMPLE_BITS+BW)'(span_abs) * (SAMPLE_BITS+BW)'(BAND_RECIP);
    band      = band_prod[BN +: SAMPLE_BITS];
  end

endmodule

@@ design/tdrs_seq.sv @@
`timescale 1ns / 1ps

module tdrs_seq #(
  parameter int SAMPLE_BITS      = tdrs_pkg::SAMPLE_BITS_DEF,
  parameter int TICK_BITS        = tdrs_pkg::TICK_BITS_DEF,
  parameter int CHANGE_DEAD_BAND = tdrs_pkg::CHANGE_DEAD_BAND_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   accept,
  input  logic [tdrs_pkg::CMD_BITS-1:0]          command,
  input  logic [SAMPLE_BITS-1:0]                 light_sample,
  input  tdrs_pkg::cfg_t                         cfg,
  input  logic [SAMPLE_BITS-1:0]                 target_calc,
  input  logic [SAMPLE_BITS-1:0]                 band_calc,
  output logic [SAMPLE_BITS-1:0]                 min_level,
  output logic [SAMPLE_BITS-1:0]                 max_level,
  output logic [tdrs_pkg::RES_FIXED_BITS+2*SAMPLE_BITS-1:0] res_word
);

  localparam int CW = (TICK_BITS > tdrs_pkg::CFG_BITS) ? TICK_BITS : tdrs_pkg::CFG_BITS;
  localparam logic [SAMPLE_BITS:0] BAND_LIMIT = (SAMPLE_BITS+1)'(CHANGE_DEAD_BAND);

  tdrs_pkg::phase_t            phase_reg, phase_reg_next;
  logic [TICK_BITS-1:0]        tick_now, tick_now_next;
  logic [TICK_BITS-1:0]        phase_start, phase_start_next;
  logic [TICK_BITS-1:0]        sequence_start, sequence_start_next;
  logic [TICK_BITS-1:0]        sense_start, sense_start_next;
  logic [SAMPLE_BITS-1:0]      prior_sample, prior_sample_next;
  logic signed [SAMPLE_BITS:0] level_change, level_change_next;
  logic [SAMPLE_BITS-1:0]      min_level_next, max_level_next;
  logic [SAMPLE_BITS-1:0]      dead_band;
  logic [SAMPLE_BITS-1:0]      target_level, target_level_next;
  logic                        target_higher, target_higher_next;
  logic                        relay_reg, relay_reg_next;
  logic [SAMPLE_BITS-1:0]      latest, latest_next;
  logic                        band_pending, band_pending_next;
  tdrs_pkg::event_t            ev;

  logic [TICK_BITS-1:0]              now;
  logic [TICK_BITS-1:0]              geton_elapsed;
  logic [tdrs_pkg::WORD_BITS-1:0]    geton_sum;
  logic signed [SAMPLE_BITS:0]       set_gap;
  logic                              heading_up;

  function automatic logic waited(input logic [TICK_BITS-1:0] now_v,
                                  input logic [TICK_BITS-1:0] start_v,
                                  input tdrs_pkg::cfg_word_t  dur);
    logic [TICK_BITS-1:0] elapsed;
    elapsed = now_v - start_v;
    return CW'(elapsed) > CW'(dur);
  endfunction

  function automatic logic [SAMPLE_BITS:0] magnitude(input logic signed [SAMPLE_BITS:0] v);
    return v[SAMPLE_BITS] ? -v : v;
  endfunction

  function automatic logic lit(input logic [SAMPLE_BITS-1:0] sample,
                               input logic [SAMPLE_BITS-1:0] floor_level);
    return sample > (floor_level >> 1);
  endfunction

  always_comb begin
    phase_reg_next      = phase_reg;
    tick_now_next       = tick_now;
    phase_start_next    = phase_start;
    sequence_start_next = sequence_start;
    sense_start_next    = sense_start;
    prior_sample_next   = prior_sample;
    level_change_next   = level_change;
    min_level_next      = min_level;
    max_level_next      = max_level;
    target_level_next   = target_level;
    target_higher_next  = target_higher;
    relay_reg_next      = relay_reg;
    latest_next         = latest;
    band_pending_next   = 1'b0;
    ev                  = tdrs_pkg::EV_NONE;

    now           = TICK_BITS'(tick_now + 1'b1);
    geton_elapsed = now - phase_start;
    geton_sum     = tdrs_pkg::WORD_BITS'(geton_elapsed)
                  + tdrs_pkg::WORD_BITS'(cfg.ramp_start_ticks);
    set_gap       = $signed({1'b0, target_level}) - $signed({1'b0, light_sample});
    heading_up    = light_sample < target_level;

    if (accept) begin
      case (command)
        tdrs_pkg::CMD_TICK: begin
          tick_now_next = now;
          latest_next   = light_sample;
          if (phase_reg != tdrs_pkg::PH_IDLE) begin
            case (phase_reg)
              tdrs_pkg::PH_TOG: begin
                sequence_start_next = now;
                relay_reg_next      = 1'b1;
                phase_start_next    = now;
                phase_reg_next      = tdrs_pkg::PH_TOG_FIN;
              end
              tdrs_pkg::PH_TOG_FIN: begin
                if (waited(now, phase_start, cfg.press_ticks)) begin
                  relay_reg_next = 1'b0;
                  phase_reg_next = tdrs_pkg::PH_IDLE;
                end
              end
              tdrs_pkg::PH_ON: begin
                sequence_start_next = now;
                if (!lit(light_sample, min_level)) begin
                  relay_reg_next   = 1'b1;
                  phase_start_next = now;
                  phase_reg_next   = tdrs_pkg::PH_ON_PRESS;
                end else begin
                  phase_reg_next = tdrs_pkg::PH_IDLE;
                  ev             = tdrs_pkg::EV_ALREADY_ON;
                end
              end
              tdrs_pkg::PH_ON_PRESS: begin
                if (waited(now, phase_start, cfg.press_ticks)) begin
                  relay_reg_next   = 1'b0;
                  phase_start_next = now;
                  phase_reg_next   = tdrs_pkg::PH_ON_CHECK;
                end
              end
              tdrs_pkg::PH_ON_CHECK: begin
                if (waited(now, phase_start, cfg.on_wait_ticks)) begin
                  if (!lit(light_sample, min_level)) ev = tdrs_pkg::EV_NOT_ON;
                  phase_reg_next = tdrs_pkg::PH_IDLE;
                end
              end
              tdrs_pkg::PH_OFF: begin
                sequence_start_next = now;
                if (lit(light_sample, min_level)) begin
                  relay_reg_next   = 1'b1;
                  phase_start_next = now;
                  phase_reg_next   = tdrs_pkg::PH_OFF_PRESS;
                end else begin
                  phase_reg_next = tdrs_pkg::PH_IDLE;
                  ev             = tdrs_pkg::EV_ALREADY_OFF;
                end
              end
              tdrs_pkg::PH_OFF_PRESS: begin
                if (waited(now, phase_start, cfg.press_ticks)) begin
                  relay_reg_next   = 1'b0;
                  phase_start_next = now;
                  phase_reg_next   = tdrs_pkg::PH_OFF_CHECK;
                end
              end
              tdrs_pkg::PH_OFF_CHECK: begin
                if (waited(now, phase_start, cfg.off_wait_ticks)) begin
                  if (lit(light_sample, min_level)) ev = tdrs_pkg::EV_NOT_OFF;
                  phase_reg_next = tdrs_pkg::PH_IDLE;
                end
              end
              tdrs_pkg::PH_CAL: begin
                sequence_start_next = now;
                sense_start_next    = now;
                prior_sample_next   = light_sample;
                relay_reg_next      = 1'b1;
                phase_start_next    = now;
                phase_reg_next      = tdrs_pkg::PH_CAL_ACC;
              end
              tdrs_pkg::PH_CAL_ACC: begin
                if (waited(now, phase_start, cfg.ramp_start_ticks)) begin
                  phase_reg_next = tdrs_pkg::PH_CAL_LIM;
                end
              end
              tdrs_pkg::PH_CAL_LIM: begin
                if (waited(now, phase_start, cfg.travel_limit_ticks)
                    || magnitude(level_change) <= BAND_LIMIT) begin
                  min_level_next   = light_sample;
                  relay_reg_next   = 1'b0;
                  phase_start_next = now;
                  phase_reg_next   = tdrs_pkg::PH_CAL_REL;
                end
              end
              tdrs_pkg::PH_CAL_REL: begin
                if (waited(now, phase_start, cfg.gap_ticks)) begin
                  sequence_start_next = now;
                  relay_reg_next      = 1'b1;
                  phase_start_next    = now;
                  phase_reg_next      = tdrs_pkg::PH_CAL_ACC2;
                end
              end
              tdrs_pkg::PH_CAL_ACC2: begin
                if (waited(now, phase_start, cfg.ramp_start_ticks)) begin
                  phase_reg_next = tdrs_pkg::PH_CAL_LIM2;
                end
              end
              tdrs_pkg::PH_CAL_LIM2: begin
                if (waited(now, phase_start, cfg.travel_limit_ticks)
                    || magnitude(level_change) <= BAND_LIMIT) begin
                  relay_reg_next = 1'b0;
                  if (light_sample < min_level) begin
                    max_level_next = min_level;
                    min_level_next = light_sample;
                  end else begin
                    max_level_next = light_sample;
                  end
                  // dead band is registered in the cycle after, from the stored levels
                  band_pending_next = 1'b1;
                  phase_reg_next    = tdrs_pkg::PH_IDLE;
                  ev                = tdrs_pkg::EV_CALIBRATED;
                end
              end
              tdrs_pkg::PH_SET: begin
                sequence_start_next = now;
                sense_start_next    = now;
                prior_sample_next   = light_sample;
                if (magnitude(set_gap) < {1'b0, dead_band}) begin
                  phase_reg_next = tdrs_pkg::PH_IDLE;
                  ev             = tdrs_pkg::EV_ON_TARGET;
                end else begin
                  relay_reg_next   = 1'b1;
                  phase_start_next = now;
                  phase_reg_next   = lit(light_sample, min_level) ? tdrs_pkg::PH_SET_ACC
                                                                  : tdrs_pkg::PH_SET_GETON;
                end
              end
              tdrs_pkg::PH_SET_GETON: begin
                if (geton_sum > tdrs_pkg::WORD_BITS'(cfg.on_wait_ticks)) begin
                  phase_start_next = now;
                  phase_reg_next   = tdrs_pkg::PH_SET_ACC;
                end
              end
              tdrs_pkg::PH_SET_ACC: begin
                if (waited(now, phase_start, cfg.ramp_start_ticks)) begin
                  target_higher_next = heading_up;
                  if (heading_up == (level_change > 0)) begin
                    phase_reg_next = tdrs_pkg::PH_SET_SEEK;
                  end else begin
                    relay_reg_next   = 1'b0;
                    phase_start_next = now;
                    phase_reg_next   = tdrs_pkg::PH_SET_REL;
                  end
                end
              end
              tdrs_pkg::PH_SET_REL: begin
                if (waited(now, phase_start, cfg.gap_ticks)) begin
                  relay_reg_next   = 1'b1;
                  phase_start_next = now;
                  phase_reg_next   = tdrs_pkg::PH_SET_ACC2;
                end
              end
              tdrs_pkg::PH_SET_ACC2: begin
                if (waited(now, phase_start, cfg.ramp_start_ticks)) begin
                  phase_reg_next = tdrs_pkg::PH_SET_SEEK;
                end
              end
              tdrs_pkg::PH_SET_SEEK: begin
                if (target_higher == (light_sample > target_level)
                    || magnitude(level_change) <= BAND_LIMIT) begin
                  phase_reg_next = tdrs_pkg::PH_SET_FIN;
                end
              end
              tdrs_pkg::PH_SET_FIN: begin
                relay_reg_next = 1'b0;
                phase_reg_next = tdrs_pkg::PH_IDLE;
                ev             = tdrs_pkg::EV_FINALIZED;
              end
              default: begin
                phase_reg_next = tdrs_pkg::PH_IDLE;
              end
            endcase

            // global timeout, then periodic change sensing in the ramp sequences
            if (phase_reg_next != tdrs_pkg::PH_IDLE) begin
              if (waited(now, sequence_start_next, cfg.timeout_ticks)) begin
                phase_reg_next = tdrs_pkg::PH_IDLE;
                ev             = tdrs_pkg::EV_TIMEOUT;
              end else if (phase_reg_next >= tdrs_pkg::PH_CAL
                           && waited(now, sense_start_next, cfg.sense_interval_ticks)) begin
                level_change_next = $signed({1'b0, light_sample})
                                  - $signed({1'b0, prior_sample_next});
                prior_sample_next = light_sample;
                sense_start_next  = now;
              end
            end
          end
        end
        tdrs_pkg::CMD_TOGGLE:    phase_reg_next = tdrs_pkg::PH_TOG;
        tdrs_pkg::CMD_POWER_ON:  phase_reg_next = tdrs_pkg::PH_ON;
        tdrs_pkg::CMD_POWER_OFF: phase_reg_next = tdrs_pkg::PH_OFF;
        tdrs_pkg::CMD_CALIBRATE: phase_reg_next = tdrs_pkg::PH_CAL;
        tdrs_pkg::CMD_SET_LEVEL: begin
          target_level_next = target_calc;
          phase_reg_next    = tdrs_pkg::PH_SET;
        end
        tdrs_pkg::CMD_QUIT: begin
          relay_reg_next = 1'b0;
          phase_reg_next = tdrs_pkg::PH_IDLE;
          ev             = tdrs_pkg::EV_QUIT;
        end
        default: ;
      endcase
    end

    res_word = {relay_reg_next, phase_reg_next == tdrs_pkg::PH_IDLE,
                lit(latest_next, min_level_next), phase_reg_next, ev,
                min_level_next, max_level_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg      <= tdrs_pkg::PH_IDLE;
      tick_now       <= '0;
      phase_start    <= '0;
      sequence_start <= '0;
      sense_start    <= '0;
      prior_sample   <= '0;
      level_change   <= '0;
      min_level      <= '0;
      max_level      <= '1;
      dead_band      <= '0;
      target_level   <= '0;
      target_higher  <= 1'b0;
      relay_reg      <= 1'b0;
      latest         <= '0;
      band_pending   <= 1'b0;
    end else begin
      phase_reg      <= phase_reg_next;
      tick_now       <= tick_now_next;
      phase_start    <= phase_start_next;
      sequence_start <= sequence_start_next;
      sense_start    <= sense_start_next;
      prior_sample   <= prior_sample_next;
      level_change   <= level_change_next;
      min_level      <= min_level_next;
      max_level      <= max_level_next;
      target_level   <= target_level_next;
      target_higher  <= target_higher_next;
      relay_reg      <= relay_reg_next;
      latest         <= latest_next;
      band_pending   <= band_pending_next;
      if (band_pending) begin
        dead_band <= band_calc;
      end
    end
  end

`ifndef SYNTHESIS
  a_quit_opens_relay: assert property (@(posedge clk) disable iff (rst)
    (accept && command == tdrs_pkg::CMD_QUIT)
    |=> (!relay_reg && phase_reg == tdrs_pkg::PH_IDLE))
    else $error("quit item left relay closed or sequence running");

  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    (accept && command == tdrs_pkg::CMD_TICK)
    |=> tick_now == TICK_BITS'($past(tick_now) + 1'b1))
    else $error("tick counter did not advance on a tick item");

  a_tick_holds: assert property (@(posedge clk) disable iff (rst)
    !(accept && command == tdrs_pkg::CMD_TICK) |=> $stable(tick_now))
    else $error("tick counter moved without a tick item");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (accept && (command == tdrs_pkg::CMD_TOGGLE || command == tdrs_pkg::CMD_POWER_ON
                || command == tdrs_pkg::CMD_POWER_OFF || command == tdrs_pkg::CMD_CALIBRATE
                || command == tdrs_pkg::CMD_SET_LEVEL))
    |=> phase_reg != tdrs_pkg::PH_IDLE)
    else $error("sequence command did not start a sequence");

  a_cal_order: assert property (@(posedge clk) disable iff (rst)
    $rose(band_pending) |-> min_level <= max_level)
    else $error("calibration stored an inverted range");
`endif

endmodule

@@ design/tdrs_res_queue.sv @@
`timescale 1ns / 1ps

module tdrs_res_queue #(
  parameter int WIDTH = tdrs_pkg::RES_FIXED_BITS + 2 * tdrs_pkg::SAMPLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             can_push,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH      = 2;
  localparam int PTR_BITS   = $clog2(DEPTH);
  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]      slots [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [COUNT_BITS-1:0] count;
  logic                  pop;

  assign can_push  = count != COUNT_BITS'(DEPTH);
  assign pop_valid = count != '0;
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
